FILE: hdl/tcr_pkg.sv
// Shared types, constants and helper functions for the timecode frame ring lookup.
package tcr_pkg;

    // Ring geometry and field widths.
    localparam int SLOTS  = 8;
    localparam int SLOT_W = 3;
    localparam int STEP_W = 4;
    localparam int TC_W   = 47;
    localparam int DUR_W  = 32;
    localparam int REQ_W  = 3;
    localparam int AVL_W  = 3;
    localparam int FREE_W = 4;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE  = 3'd0,
        REQ_SEEK   = 3'd1,
        REQ_PROBE  = 3'd2,
        REQ_LATEST = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_e_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_OUT
    } state_t;

    // One slot as seen on the read port: a valid flag and its stored timecode.
    typedef struct packed {
        logic            vld;
        logic [TC_W-1:0] tc;
    } slot_entry_t;

    // Write and clear controls from the sequencer to the slot store.
    typedef struct packed {
        logic              we;
        logic              clear;
        logic [SLOT_W-1:0] waddr;
    } store_ctrl_t;

    // Advance a slot index with wrap.
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
        logic [SLOT_W-1:0] r;
        if (p == SLOT_W'(SLOTS - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Step a slot index back with wrap.
    function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] p);
        logic [SLOT_W-1:0] r;
        if (p == '0) begin
            r = SLOT_W'(SLOTS - 1);
        end else begin
            r = p - 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: hdl/tcr_store.sv
// Slot store: per-slot timecode registers with valid flags, one write and one read port.
module tcr_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcr_pkg::store_ctrl_t        ctrl,
    input  logic [tcr_pkg::TC_W-1:0]    wdata,
    input  logic [tcr_pkg::SLOT_W-1:0]  raddr,
    output tcr_pkg::slot_entry_t        rdata
);
    import tcr_pkg::*;

    logic [TC_W-1:0]  tc_reg [SLOTS];
    logic [SLOTS-1:0] vld_reg;

    // Valid flags: a clear empties every slot at once, a write fills one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (ctrl.clear) begin
            vld_reg <= '0;
        end else if (ctrl.we) begin
            vld_reg[ctrl.waddr] <= 1'b1;
        end
    end

    // Timecode payload needs no reset; the valid flag guards it.
    always_ff @(posedge clk)
    begin
        if (ctrl.we) begin
            tc_reg[ctrl.waddr] <= wdata;
        end
    end

    // Read port.
    assign rdata.vld = vld_reg[raddr];
    assign rdata.tc  = tc_reg[raddr];

endmodule

FILE: hdl/tcr_match.sv
// Window compare unit: tests whether a query falls in [stored, stored + duration).
module tcr_match (
    input  tcr_pkg::slot_entry_t       entry,
    input  logic [tcr_pkg::TC_W-1:0]   query,
    input  logic [tcr_pkg::DUR_W-1:0]  duration,
    output logic                       holds
);
    import tcr_pkg::*;

    logic [TC_W:0] diff;
    logic          borrow;
    logic          in_window;

    // One wide subtract; its borrow says the query lies before the stored timecode.
    assign diff   = {1'b0, query} - {1'b0, entry.tc};
    assign borrow = diff[TC_W];

    // Offset must fit below the frame duration.
    assign in_window = (diff[TC_W-1:DUR_W] == '0) && (diff[DUR_W-1:0] < duration);

    // An empty slot never matches.
    assign holds = entry.vld && !borrow && in_window;

endmodule

FILE: hdl/timecode_frame_ring_lookup.sv
// Top level: request sequencer, ring pointers and result register of the frame ring lookup.
//
//  Channel  | Direction | Handshake            | Payload
//  request  | in        | req_valid/req_stall  | req_type, timecode
//  response | out       | rsp_valid/rsp_stall  | slot, hit, available, free_space
//  config   | in        | duration_we          | frame_duration
//
//  Write, latest, clear and unused codes go from idle straight to the output state,
//  where the result is offered until the response transaction completes.
//  Seek and probe walk the ring through the one shared compare unit, one slot per
//  cycle, up to SLOTS + 1 tests, and then move to the output state.
//  Reset empties all slots, zeroes both pointers and sets the frame duration to 1.
//  req_stall stays high from acceptance until the response transaction completes.
module timecode_frame_ring_lookup (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [tcr_pkg::REQ_W-1:0]    req_type,
    input  logic [tcr_pkg::TC_W-1:0]     timecode,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [tcr_pkg::SLOT_W-1:0]   slot,
    output logic                         hit,
    output logic [tcr_pkg::AVL_W-1:0]    available,
    output logic [tcr_pkg::FREE_W-1:0]   free_space,
    input  logic                         duration_we,
    input  logic [tcr_pkg::DUR_W-1:0]    frame_duration
);
    import tcr_pkg::*;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [SLOT_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [SLOT_W-1:0]   walk_reg, walk_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [TC_W-1:0]     query_reg, query_next;
    logic                seek_reg, seek_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                hit_reg, hit_next;
    logic [DUR_W-1:0]    duration_reg;

    logic                accept;
    logic                out_done;
    logic                is_search;
    logic                found;
    logic                stop_empty;
    logic                stop_end;
    req_e_t              req_code;
    store_ctrl_t         store_ctrl;
    slot_entry_t         entry;

    assign req_code  = req_e_t'(req_type);
    assign accept    = req_valid && !req_stall;
    assign out_done  = rsp_valid && !rsp_stall;
    assign is_search = (req_code == REQ_SEEK) || (req_code == REQ_PROBE);

    // Slot storage and the shared window compare.
    tcr_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (store_ctrl),
        .wdata (timecode),
        .raddr (walk_reg),
        .rdata (entry)
    );

    tcr_match u_match (
        .entry    (entry),
        .query    (query_reg),
        .duration (duration_reg),
        .holds    (found)
    );

    // Walk termination: an empty slot after the first test, or the ring fully covered.
    assign stop_empty = (step_reg != '0) && !entry.vld;
    assign stop_end   = (step_reg == STEP_W'(SLOTS));

    // Frame duration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            duration_reg <= DUR_W'(1);
        end else if (duration_we) begin
            duration_reg <= frame_duration;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            step_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            step_reg   <= step_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        walk_reg  <= walk_next;
        query_reg <= query_next;
        seek_reg  <= seek_next;
        slot_reg  <= slot_next;
        hit_reg   <= hit_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    state_next = is_search ? ST_SEARCH : ST_OUT;
                end
            end
            ST_SEARCH:
            begin
                if (stop_empty || found || stop_end) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_done) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs and store controls.
    always_comb
    begin
        req_stall        = 1'b1;
        rsp_valid        = 1'b0;
        store_ctrl.we    = 1'b0;
        store_ctrl.clear = 1'b0;
        store_ctrl.waddr = wr_ptr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall        = 1'b0;
                store_ctrl.we    = req_valid && (req_code == REQ_WRITE);
                store_ctrl.clear = req_valid && (req_code == REQ_CLEAR);
            end
            ST_SEARCH:
            begin
                req_stall = 1'b1;
            end
            ST_OUT:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Datapath: pointer updates, walk sequencing and the result register.
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        walk_next   = walk_reg;
        step_next   = step_reg;
        query_next  = query_reg;
        seek_next   = seek_reg;
        slot_next   = slot_reg;
        hit_next    = hit_reg;
        if (state_reg == ST_IDLE && accept) begin
            query_next = timecode;
            seek_next  = (req_code == REQ_SEEK);
            walk_next  = rd_ptr_reg;
            step_next  = '0;
            slot_next  = rd_ptr_reg;
            hit_next   = 1'b1;
            unique case (req_code)
                REQ_WRITE:
                begin
                    slot_next   = wr_ptr_reg;
                    wr_ptr_next = next_slot(wr_ptr_reg);
                end
                REQ_SEEK, REQ_PROBE:
                begin
                    slot_next = rd_ptr_reg;
                end
                REQ_LATEST:
                begin
                    rd_ptr_next = prev_slot(wr_ptr_reg);
                    slot_next   = prev_slot(wr_ptr_reg);
                end
                REQ_CLEAR:
                begin
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    slot_next   = '0;
                end
                default:
                begin
                    hit_next = 1'b0;
                end
            endcase
        end else if (state_reg == ST_SEARCH) begin
            if (stop_empty || (!found && stop_end)) begin
                // Miss: report the old read slot; a seek falls back to the newest frame.
                slot_next = rd_ptr_reg;
                hit_next  = 1'b0;
                if (seek_reg) begin
                    rd_ptr_next = prev_slot(wr_ptr_reg);
                end
            end else if (found) begin
                slot_next = walk_reg;
                hit_next  = 1'b1;
                if (seek_reg) begin
                    rd_ptr_next = walk_reg;
                end
            end else begin
                walk_next = next_slot(walk_reg);
                step_next = step_reg + 1'b1;
            end
        end
    end

    // Response payload; occupancy follows the pointers, which hold while a result waits.
    assign slot       = slot_reg;
    assign hit        = hit_reg;
    assign available  = wr_ptr_reg - rd_ptr_reg;
    assign free_space = FREE_W'(SLOTS) - {1'b0, available};

    // The walk never goes past one full turn of the ring.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (step_reg <= STEP_W'(SLOTS)))
        else $error("search step count exceeded ring size");

    // A request that needs no search is answered in the next cycle.
    a_direct_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_search) |=> rsp_valid)
        else $error("direct request not answered in the next cycle");

    // No result is repeated once it has been taken.
    a_single_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        out_done |=> !rsp_valid)
        else $error("response repeated");

    // A probe never moves the read pointer.
    a_probe_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && !seek_reg) |=> $stable(rd_ptr_reg))
        else $error("probe moved the read pointer");

    // A found slot always reports a hit.
    a_found_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && found) |=> (hit_reg && rsp_valid))
        else $error("match not reported as hit");

endmodule
